### rtl/sbpm_pkg.sv
`timescale 1ns / 1ps

package sbpm_pkg;

	// request kinds carried on s_tuser
	localparam logic [1:0] REQ_INIT   = 2'd0;
	localparam logic [1:0] REQ_TAKE   = 2'd1;
	localparam logic [1:0] REQ_MARK   = 2'd2;
	localparam logic [1:0] REQ_RETURN = 2'd3;

	// result status codes
	localparam logic [3:0] STS_OK        = 4'd0;
	localparam logic [3:0] STS_EMPTY     = 4'd1;
	localparam logic [3:0] STS_USED      = 4'd2;
	localparam logic [3:0] STS_RANGE     = 4'd3;
	localparam logic [3:0] STS_PAGE_FREE = 4'd4;
	localparam logic [3:0] STS_BUF_FREE  = 4'd5;
	localparam logic [3:0] STS_LEN       = 4'd6;
	localparam logic [3:0] STS_MISALIGN  = 4'd7;
	localparam logic [3:0] STS_FULL      = 4'd8;

	// configuration register indexes
	localparam logic CFG_SHIFT = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	// reset values of the configuration registers
	localparam logic [4:0] SHIFT_RESET = 5'd20;
	localparam logic [8:0] COUNT_RESET = 9'd256;

	// 8 KiB buffers
	localparam logic [4:0] BUF_SHIFT = 5'd13;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_EXEC  = 4'b1000
	} state_t;

endpackage

### rtl/superpage_buffer_pool_manager.sv
`timescale 1ns / 1ps

// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+------------------------------------------
// s_*       | in        | s_tvalid / s_tready | tuser: req_type; tdata: buf_offset, buf_len
// m_*       | out       | m_tvalid / m_tready | tdata: status, superpage_index,
//           |           |                     |        free_count, page_returned
// cfg_*     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// take, mark and return items pass through accept, memory read, then update and result
// init sweeps every page record, one per cycle, then gives its result
// after reset the same sweep clears the page records; no item is taken until it ends,
// configuration writes are taken throughout
// the update cycle waits while the output register still holds an untaken result
// state lives in three one-port memories (free stack, page bitmaps, buffer lengths)

module superpage_buffer_pool_manager
	import sbpm_pkg::*;
#(
	parameter int MAX_SUPERPAGES    = 256,
	parameter int MAX_BUFS_PER_PAGE = 128,
	parameter int LEN_BITS          = 24
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // [27:0] buf_offset, [51:28] buf_len, [55:52] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [3:0] status, [11:4] superpage_index,
	                               // [20:12] free_count, [21] page_returned, [23:22] zero

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int PAGE_W  = $clog2(MAX_SUPERPAGES);
	localparam int DEPTH_W = $clog2(MAX_SUPERPAGES + 1);
	localparam int BUF_W   = (MAX_BUFS_PER_PAGE > 1) ? $clog2(MAX_BUFS_PER_PAGE) : 1;
	localparam int BUF_LOG = $clog2(MAX_BUFS_PER_PAGE + 1) - 1;  // floor of log2
	localparam int SLOTS   = MAX_SUPERPAGES * MAX_BUFS_PER_PAGE;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// configuration
	logic [4:0] shift_q;
	logic [8:0] count_q;

	// control
	state_t             state_q;
	logic [PAGE_W-1:0]  sweep_q;
	logic               sweep_init_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               m_valid_q;

	// item registers
	logic [1:0]          req_s1;
	logic [PAGE_W-1:0]   page_s1;
	logic [BUF_W-1:0]    buf_s1;
	logic                range_s1;
	logic                misal_s1;
	logic [LEN_BITS-1:0] len_s1;

	// result register
	logic [3:0]          sts_q;
	logic [7:0]          idx_q;
	logic [8:0]          fc_q;
	logic                ret_q;

	// memories and their read registers
	logic [PAGE_W-1:0]            stack_mem [MAX_SUPERPAGES];
	logic [MAX_BUFS_PER_PAGE-1:0] bits_mem  [MAX_SUPERPAGES];
	logic [LEN_BITS-1:0]          len_mem   [SLOTS];
	logic [PAGE_W-1:0]            stack_rd_q;
	logic [MAX_BUFS_PER_PAGE-1:0] bits_rd_q;
	logic [LEN_BITS-1:0]          len_rd_q;

	// effective shift above 8 KiB and effective count
	logic [4:0]         sh_rel;
	logic [DEPTH_W-1:0] eff_count;

	always_comb begin
		if (shift_q < BUF_SHIFT)
			sh_rel = 5'd0;
		else if (shift_q - BUF_SHIFT > 5'(BUF_LOG))
			sh_rel = 5'(BUF_LOG);
		else
			sh_rel = shift_q - BUF_SHIFT;
	end

	always_comb begin
		if (count_q == 9'd0)
			eff_count = DEPTH_W'(1);
		else if (32'(count_q) > 32'(MAX_SUPERPAGES))
			eff_count = DEPTH_W'(MAX_SUPERPAGES);
		else
			eff_count = DEPTH_W'(count_q);
	end

	// offset decode at accept
	logic [14:0] off_hi;
	logic [14:0] page_full;
	logic [14:0] buf_mask;
	logic [14:0] buf_full;

	assign off_hi    = s_tdata[27:13];
	assign page_full = off_hi >> sh_rel;
	assign buf_mask  = (15'(1) << sh_rel) - 15'(1);
	assign buf_full  = off_hi & buf_mask;

	logic in_fire;
	logic out_free;
	logic exec_fire;
	logic sweep_last;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_fire    = s_tvalid && s_tready;
	assign out_free   = !m_valid_q || m_tready;
	assign exec_fire  = (state_q == ST_EXEC) && out_free;
	assign sweep_last = (sweep_q == PAGE_W'(MAX_SUPERPAGES - 1));
	assign cfg_ready  = 1'b1;

	// update step
	logic [SLOT_W-1:0]            slot;
	logic [MAX_BUFS_PER_PAGE-1:0] buf_bit;
	logic [MAX_BUFS_PER_PAGE-1:0] bits_clr;
	logic [3:0]                   r_sts;
	logic [PAGE_W-1:0]            r_page;
	logic                         r_ret;
	logic                         bits_we;
	logic [MAX_BUFS_PER_PAGE-1:0] bits_wd;
	logic                         len_we;
	logic                         push;
	logic                         pop;

	assign slot     = SLOT_W'(page_s1) * SLOT_W'(MAX_BUFS_PER_PAGE) + SLOT_W'(buf_s1);
	assign buf_bit  = MAX_BUFS_PER_PAGE'(1) << buf_s1;
	assign bits_clr = bits_rd_q & ~buf_bit;

	always_comb begin
		r_sts   = STS_OK;
		r_page  = '0;
		r_ret   = 1'b0;
		bits_we = 1'b0;
		bits_wd = bits_rd_q | buf_bit;
		len_we  = 1'b0;
		push    = 1'b0;
		pop     = 1'b0;
		unique case (req_s1) inside
			REQ_INIT: begin
				r_sts = STS_OK;
			end
			REQ_TAKE: begin
				if (depth_q == '0) begin
					r_sts = STS_EMPTY;
				end else begin
					pop    = 1'b1;
					r_page = stack_rd_q;
				end
			end
			REQ_MARK, REQ_RETURN: begin
				if (range_s1) begin
					r_sts = STS_RANGE;
				end else if (misal_s1) begin
					r_sts  = STS_MISALIGN;
					r_page = page_s1;
				end else begin
					r_page = page_s1;
					if (req_s1 == REQ_MARK) begin
						if ((bits_rd_q & buf_bit) != '0) begin
							r_sts = STS_USED;
						end else begin
							bits_we = 1'b1;
							len_we  = 1'b1;
						end
					end else if (bits_rd_q == '0) begin
						r_sts = STS_PAGE_FREE;
					end else if ((bits_rd_q & buf_bit) == '0) begin
						r_sts = STS_BUF_FREE;
					end else if (len_rd_q != len_s1) begin
						r_sts = STS_LEN;
					end else begin
						bits_we = 1'b1;
						bits_wd = bits_clr;
						// last buffer back: page returns to the stack unless it is full
						if (bits_clr == '0) begin
							if (depth_q >= eff_count) begin
								r_sts = STS_FULL;
							end else begin
								push  = 1'b1;
								r_ret = 1'b1;
							end
						end
					end
				end
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SHIFT_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SHIFT: shift_q <= cfg_data[4:0];
				CFG_COUNT: count_q <= cfg_data;
			endcase
		end
	end

	// sequencer, stack depth and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			sweep_q      <= '0;
			sweep_init_q <= 1'b0;
			depth_q      <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && !exec_fire)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (sweep_last) begin
						sweep_q      <= '0;
						sweep_init_q <= 1'b0;
						state_q      <= sweep_init_q ? ST_EXEC : ST_IDLE;
					end else begin
						sweep_q <= sweep_q + PAGE_W'(1);
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						if (s_tuser == REQ_INIT) begin
							sweep_init_q <= 1'b1;
							state_q      <= ST_CLEAR;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_fire) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
						if (req_s1 == REQ_INIT)
							depth_q <= eff_count;
						else if (pop)
							depth_q <= depth_q - DEPTH_W'(1);
						else if (push)
							depth_q <= depth_q + DEPTH_W'(1);
					end
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1   <= s_tuser;
			page_s1  <= PAGE_W'(page_full);
			buf_s1   <= BUF_W'(buf_full);
			range_s1 <= 16'(page_full) >= 16'(eff_count);
			misal_s1 <= |s_tdata[12:0];
			len_s1   <= LEN_BITS'(s_tdata[51:28]);
		end
		if (exec_fire) begin
			sts_q <= r_sts;
			idx_q <= 8'(r_page);
			ret_q <= r_ret;
			if (req_s1 == REQ_INIT)
				fc_q <= 9'(eff_count);
			else if (pop)
				fc_q <= 9'(depth_q - DEPTH_W'(1));
			else if (push)
				fc_q <= 9'(depth_q + DEPTH_W'(1));
			else
				fc_q <= 9'(depth_q);
		end
	end

	// free stack: init fill during the sweep, push on return, pop read
	logic              stk_we;
	logic [PAGE_W-1:0] stk_wa;
	logic [PAGE_W-1:0] stk_wd;
	logic [PAGE_W-1:0] stk_top;

	assign stk_top = PAGE_W'(depth_q - DEPTH_W'(1));

	always_comb begin
		if (state_q == ST_CLEAR) begin
			stk_we = sweep_init_q && (DEPTH_W'(sweep_q) < eff_count);
			stk_wa = sweep_q;
			stk_wd = sweep_q;
		end else begin
			stk_we = exec_fire && push;
			stk_wa = PAGE_W'(depth_q);
			stk_wd = page_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stack_mem[stk_wa] <= stk_wd;
		if (state_q == ST_READ)
			stack_rd_q <= stack_mem[stk_top];
	end

	// page bitmaps: cleared by the sweep, updated on mark and return
	logic                         bm_we;
	logic [PAGE_W-1:0]            bm_wa;
	logic [MAX_BUFS_PER_PAGE-1:0] bm_wd;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			bm_we = 1'b1;
			bm_wa = sweep_q;
			bm_wd = '0;
		end else begin
			bm_we = exec_fire && bits_we;
			bm_wa = page_s1;
			bm_wd = bits_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (bm_we)
			bits_mem[bm_wa] <= bm_wd;
		if (state_q == ST_READ)
			bits_rd_q <= bits_mem[page_s1];
	end

	// buffer lengths, only compared for buffers marked used
	always_ff @(posedge clk) begin
		if (exec_fire && len_we)
			len_mem[slot] <= len_s1;
		if (state_q == ST_READ)
			len_rd_q <= len_mem[slot];
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, ret_q, fc_q, idx_q, sts_q};

endmodule
